### design/pls_pkg.sv
// Package for the positional list store: shared constants, operation and
// status codes, and the per-cell shift select.
// Used by the interfaces, the cell, the cell row and the top level.
`default_nettype none

package pls_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VAL_W        = 32;
   localparam int POS_W        = 8;
   localparam int OP_W         = 3;
   localparam int ST_W         = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_DUMP_FWD  = 3'd6,
      OP_DUMP_REV  = 3'd7
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_POS   = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Command broadcast to the whole row of cells.
   typedef enum logic [2:0] {
      CH_HOLD   = 3'd0,
      CH_INSERT = 3'd1,
      CH_DELETE = 3'd2,
      CH_ROT_L  = 3'd3,
      CH_ROT_R  = 3'd4
   } chain_cmd_type;

   // What one cell loads in a cycle.
   typedef enum logic [1:0] {
      SEL_HOLD  = 2'd0,
      SEL_LEFT  = 2'd1,
      SEL_RIGHT = 2'd2,
      SEL_NEW   = 2'd3
   } cell_sel_type;

endpackage

`default_nettype wire

### design/pls_req_if.sv
// Request channel interface of the positional list store.
// Depends on pls_pkg for field widths.
`default_nettype none

interface pls_req_if;
   import pls_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [VAL_W-1:0] value;
   logic [POS_W-1:0] position;

   modport source (output valid, output operation, output value, output position,
                   input ready);
   modport sink   (input valid, input operation, input value, input position,
                   output ready);
endinterface

`default_nettype wire

### design/pls_rsp_if.sv
// Response channel interface of the positional list store.
// Depends on pls_pkg for field widths; CNT_W follows the list capacity.
`default_nettype none

interface pls_rsp_if #(
   parameter int CNT_W = $clog2(pls_pkg::CAPACITY_DEF + 1)
);
   import pls_pkg::*;

   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic [VAL_W-1:0] element;
   logic             is_last;
   logic [CNT_W-1:0] count;

   modport source (output valid, output status, output element, output is_last,
                   output count, input ready);
   modport sink   (input valid, input status, input element, input is_last,
                   input count, output ready);
endinterface

`default_nettype wire

### design/pls_cell.sv
// One storage cell of the list row: holds a value or loads it from its left
// neighbor, its right neighbor or the broadcast data. Depends on pls_pkg.
`default_nettype none

module pls_cell (
   input  wire logic                      clock,
   input  wire pls_pkg::cell_sel_type     sel,
   input  wire logic [pls_pkg::VAL_W-1:0] left_d,
   input  wire logic [pls_pkg::VAL_W-1:0] right_d,
   input  wire logic [pls_pkg::VAL_W-1:0] new_d,
   output logic      [pls_pkg::VAL_W-1:0] q
);
   import pls_pkg::*;

   logic [VAL_W-1:0] data_ff;
   logic [VAL_W-1:0] data_in;

   always_comb begin
      case (sel)
         SEL_HOLD:  data_in = data_ff;
         SEL_LEFT:  data_in = left_d;
         SEL_RIGHT: data_in = right_d;
         SEL_NEW:   data_in = new_d;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

`default_nettype wire

### design/pls_chain.sv
// Row of CAPACITY cells, element 1 in cell 0. Decodes the broadcast
// command into a per-cell select and exposes the first and last element.
// Depends on pls_pkg and pls_cell.
`default_nettype none

module pls_chain #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
   parameter int LEN_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                      clock,
   input  wire pls_pkg::chain_cmd_type    cmd,
   input  wire logic [IDX_W-1:0]          idx,
   input  wire logic [LEN_W-1:0]          len,
   input  wire logic [pls_pkg::VAL_W-1:0] new_d,
   output logic      [pls_pkg::VAL_W-1:0] head,
   output logic      [pls_pkg::VAL_W-1:0] tail
);
   import pls_pkg::*;

   logic [VAL_W-1:0] cell_q [CAPACITY];
   logic [IDX_W-1:0] tail_idx;

   // tail is read only while the list holds at least one element
   assign tail_idx = IDX_W'(len - LEN_W'(1));
   assign head     = cell_q[0];
   assign tail     = cell_q[tail_idx];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(i);
      localparam logic [LEN_W-1:0] MY_NEXT = LEN_W'(i + 1);

      cell_sel_type     sel;
      logic [VAL_W-1:0] left_d;
      logic [VAL_W-1:0] right_d;

      assign left_d  = (i == 0) ? new_d : cell_q[(i == 0) ? 0 : i - 1];
      assign right_d = (i == CAPACITY - 1) ? cell_q[i] : cell_q[(i == CAPACITY - 1) ? i : i + 1];

      always_comb begin
         case (cmd)
            CH_INSERT: begin
               if (MY_IDX < idx)       sel = SEL_HOLD;
               else if (MY_IDX == idx) sel = SEL_NEW;
               else                    sel = SEL_LEFT;
            end
            CH_DELETE: begin
               if (MY_IDX < idx) sel = SEL_HOLD;
               else              sel = SEL_RIGHT;
            end
            // rotate toward cell 0 inside the occupied part
            CH_ROT_L: begin
               if (MY_NEXT < len)       sel = SEL_RIGHT;
               else if (MY_NEXT == len) sel = SEL_NEW;
               else                     sel = SEL_HOLD;
            end
            // rotate away from cell 0 inside the occupied part
            CH_ROT_R: begin
               if (i == 0)               sel = SEL_NEW;
               else if (MY_NEXT <= len)  sel = SEL_LEFT;
               else                      sel = SEL_HOLD;
            end
            default: sel = SEL_HOLD;
         endcase
      end

      pls_cell u_cell (
         .clock   (clock),
         .sel     (sel),
         .left_d  (left_d),
         .right_d (right_d),
         .new_d   (new_d),
         .q       (cell_q[i])
      );
   end

endmodule

`default_nettype wire

### design/positional_list_store_top.sv
// Positional list store: bounded ordered list of signed 32-bit values.
// Request channel (req_if): operation, value, position; a transfer is taken
// when valid and ready are both high. Response channel (rsp_if): status,
// element, is_last, count.
// An insert or delete is done in the cycle of its transfer; its single
// response (is_last set) is in the output register on the next cycle.
// Updates therefore run at one per cycle while responses are taken.
// A dump of N elements gives N responses, one per cycle while responses are
// taken, by rotating the cell row one place per response (N rotations restore
// the order); no request is taken until the last one is loaded. A dump of an
// empty list gives one response with status empty.
// When the receiver stalls, the output register holds its response and
// requests and dump steps wait until it frees up.
// Synchronous reset empties the list and drops any pending response; cell
// contents are not cleared.
// Depends on pls_pkg, pls_req_if, pls_rsp_if, pls_chain.
`default_nettype none

module positional_list_store_top #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
   parameter int LEN_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pls_req_if.sink    req_if,
   pls_rsp_if.source  rsp_if
);
   import pls_pkg::*;

   localparam int CMP_W = POS_W + 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             rev_ff, rev_in;
   logic [LEN_W-1:0] left_ff, left_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [VAL_W-1:0] element_ff, element_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] count_ff, count_in;

   logic             out_free;
   logic             accept;
   op_type           op;
   logic [CMP_W-1:0] pos_c;
   logic [CMP_W-1:0] len_c;
   logic             full;
   logic             empty;

   chain_cmd_type    cmd;
   logic [IDX_W-1:0] idx;
   logic [VAL_W-1:0] new_d;
   logic [VAL_W-1:0] head;
   logic [VAL_W-1:0] tail;

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE) && out_free;
   assign accept        = req_if.valid && req_if.ready;
   assign op            = op_type'(req_if.operation);
   assign pos_c         = CMP_W'(req_if.position);
   assign len_c         = CMP_W'(len_ff);
   assign full          = (len_ff == LEN_W'(CAPACITY));
   assign empty         = (len_ff == '0);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rev_in       = rev_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      element_in   = element_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      cmd          = CH_HOLD;
      idx          = '0;
      new_d        = req_if.value;

      if (state_ff == S_DUMP) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            status_in    = ST_OK;
            element_in   = rev_ff ? tail : head;
            last_in      = (left_ff == LEN_W'(1));
            count_in     = len_ff;
            cmd          = rev_ff ? CH_ROT_R : CH_ROT_L;
            new_d        = rev_ff ? tail : head;
            left_in      = left_ff - LEN_W'(1);
            if (left_ff == LEN_W'(1)) state_in = S_IDLE;
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         element_in   = '0;
         last_in      = 1'b1;
         case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
               if (op == OP_INS_AT &&
                   (pos_c == '0 || pos_c > len_c + CMP_W'(1))) begin
                  status_in = ST_POS;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd    = CH_INSERT;
                  len_in = len_ff + LEN_W'(1);
                  if (op == OP_INS_FRONT)     idx = '0;
                  else if (op == OP_INS_BACK) idx = IDX_W'(len_ff);
                  else                        idx = IDX_W'(pos_c - CMP_W'(1));
               end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd    = CH_DELETE;
                  len_in = len_ff - LEN_W'(1);
                  idx    = (op == OP_DEL_FRONT) ? '0 : IDX_W'(len_ff - LEN_W'(1));
               end
            end
            OP_DEL_AT: begin
               if (pos_c == '0 || pos_c > len_c) begin
                  status_in = ST_POS;
               end else begin
                  cmd    = CH_DELETE;
                  len_in = len_ff - LEN_W'(1);
                  idx    = IDX_W'(pos_c - CMP_W'(1));
               end
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  // first element goes out with the transfer itself
                  rev_in     = (op == OP_DUMP_REV);
                  element_in = (op == OP_DUMP_REV) ? tail : head;
                  new_d      = (op == OP_DUMP_REV) ? tail : head;
                  cmd        = (op == OP_DUMP_REV) ? CH_ROT_R : CH_ROT_L;
                  last_in    = (len_ff == LEN_W'(1));
                  left_in    = len_ff - LEN_W'(1);
                  if (len_ff != LEN_W'(1)) state_in = S_DUMP;
               end
            end
            default: status_in = ST_OK;
         endcase
         count_in = len_in;
      end
   end

   pls_chain #(
      .CAPACITY (CAPACITY),
      .LEN_W    (LEN_W),
      .IDX_W    (IDX_W)
   ) u_chain (
      .clock (clock),
      .cmd   (cmd),
      .idx   (idx),
      .len   (len_ff),
      .new_d (new_d),
      .head  (head),
      .tail  (tail)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rev_ff     <= rev_in;
      left_ff    <= left_in;
      status_ff  <= status_in;
      element_ff <= element_in;
      last_ff    <= last_in;
      count_ff   <= count_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = status_ff;
   assign rsp_if.element = element_ff;
   assign rsp_if.is_last = last_ff;
   assign rsp_if.count   = count_ff;

endmodule

`default_nettype wire
